@@ design/gain_scheduled_lqr_torque_unit_macros.svh @@
// Assertion macros shared by the gain-scheduled LQR torque unit.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef GAIN_SCHEDULED_LQR_TORQUE_UNIT_MACROS_SVH
`define GAIN_SCHEDULED_LQR_TORQUE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GSLQR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GSLQR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/gslqr_pkg.sv @@
// Shared widths, structs and the gain coefficient ROM for the LQR torque unit.
// No dependencies; used by the lane, the merge stage and the top level.
package gslqr_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int NUM_LANES      = 6;
  localparam int NUM_COEF       = 4;
  localparam int LEN_W          = 16;
  localparam int ERR_W          = 32;
  localparam int OUT_W          = 32;
  localparam int COEF_W         = 32;
  localparam int FRAC_L         = 16;
  localparam int FRAC_G         = 20;
  localparam int ACC_W          = 36;
  localparam int PROD_W         = COEF_W + ERR_W;
  localparam int TERM_W         = PROD_W - FRAC_G;
  localparam int SUM_W          = 50;
  localparam int LANE_DEPTH     = 6;
  localparam int MERGE_DEPTH    = 3;
  localparam int PIPE_DEPTH     = LANE_DEPTH + MERGE_DEPTH;
  localparam longint MICRO      = 1000000;

  // Gain coefficients in units of 1e-6: L^3, L^2, L, constant.
  // Rows 0..5 feed the wheel sum, rows 6..11 the joint sum.
  localparam longint COEF_MICRO [2*NUM_LANES][NUM_COEF] = '{
    '{ -344130023,   397724995,  -265059481,   -4941964 },
    '{   11842778,   -18891159,   -27922778,     234829 },
    '{ -288953787,   281637253,   -94596365,  -10720163 },
    '{ -177996259,   181622915,   -75159282,   -7728459 },
    '{ -835889683,   930198548,  -389150660,   74543061 },
    '{  -58542501,    66926377,   -29456008,    6433743 },
    '{  178165050,  -120123702,     -177096,   29334646 },
    '{   38945329,   -38984286,    14882355,    2371578 },
    '{ -527320926,   586755646,  -245391894,   46899771 },
    '{ -343006363,   380367381,  -159679912,   32616099 },
    '{ 1840588017, -1794197881,   602816532,   67365929 },
    '{  151012003,  -149438347,    51534782,    1364543 }
  };

  // Q12.20 coefficient, rounded half away from zero; evaluated at elaboration.
  function automatic logic signed [COEF_W-1:0] coef_q20(input int g, input int k);
    longint m;
    longint r;
    m = COEF_MICRO[g][k];
    if (m >= 0) begin
      r = (m * (longint'(1) << FRAC_G) + MICRO / 2) / MICRO;
    end else begin
      r = -(((-m) * (longint'(1) << FRAC_G) + MICRO / 2) / MICRO);
    end
    return COEF_W'(r);
  endfunction

  // Per-item flags and addends that ride alongside the lanes.
  typedef struct packed {
    logic                    leg_side;
    logic                    in_air;
    logic                    weak_mode;
    logic signed [ERR_W-1:0] turn_torque;
    logic signed [ERR_W-1:0] coordinate_torque;
  } side_t;

  // One finished result word.
  typedef struct packed {
    logic signed [OUT_W-1:0] wheel_torque;
    logic signed [OUT_W-1:0] joint_torque;
    logic                    leg_force_zero;
  } res_t;

endpackage

@@ design/gslqr_lane.sv @@
// One lane: evaluates the wheel-row and joint-row gains for one state error
// and forms both rounded gain*error terms. Uses gslqr_pkg.
module gslqr_lane #(
  parameter int LANE = 0
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [gslqr_pkg::LEN_W-1:0]         len,
  input  logic signed [gslqr_pkg::ERR_W-1:0]  err,
  output logic signed [gslqr_pkg::TERM_W-1:0] term_row1,
  output logic signed [gslqr_pkg::TERM_W-1:0] term_row2
);
  import gslqr_pkg::*;

  localparam logic signed [COEF_W-1:0] C [2][NUM_COEF] = '{
    '{ coef_q20(LANE, 0), coef_q20(LANE, 1), coef_q20(LANE, 2), coef_q20(LANE, 3) },
    '{ coef_q20(LANE + NUM_LANES, 0), coef_q20(LANE + NUM_LANES, 1),
       coef_q20(LANE + NUM_LANES, 2), coef_q20(LANE + NUM_LANES, 3) }
  };
  localparam logic signed [ACC_W+LEN_W:0] HALF_L = (ACC_W+LEN_W+1)'(1) << (FRAC_L - 1);
  localparam logic signed [PROD_W-1:0]    HALF_G = PROD_W'(1) << (FRAC_G - 1);
  localparam logic signed [ACC_W-1:0]     G_MAX  =
    {{(ACC_W-COEF_W+1){1'b0}}, {(COEF_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]     G_MIN  = ~G_MAX;

  // One Horner step: R16(a * L) + c.
  function automatic logic signed [ACC_W-1:0] horner_step(
    input logic signed [ACC_W-1:0] a,
    input logic [LEN_W-1:0]        l,
    input logic signed [COEF_W-1:0] c
  );
    logic signed [ACC_W+LEN_W:0] p;
    logic signed [ACC_W:0]       q;
    p = a * $signed({1'b0, l});
    p = p + HALF_L;
    q = p[ACC_W+LEN_W:FRAC_L];
    return ACC_W'(q + (ACC_W+1)'(c));
  endfunction

  logic [LEN_W-1:0]         len_s1, len_s2;
  logic signed [ERR_W-1:0]  err_pipe [4];
  logic signed [ACC_W-1:0]  a1 [2];
  logic signed [ACC_W-1:0]  a2 [2];
  logic signed [ACC_W-1:0]  a3 [2];
  logic signed [COEF_W-1:0] gain_s4 [2];
  logic signed [PROD_W-1:0] prod_s5 [2];
  logic signed [PROD_W-1:0] prod_rnd [2];

  // Stages 1-3: Horner over L; stage 4: clamp gain; 5: product; 6: R20.
  always_ff @(posedge clk) begin
    if (en) begin
      len_s1      <= len;
      len_s2      <= len_s1;
      err_pipe[0] <= err;
      for (int i = 1; i < 4; i++) begin
        err_pipe[i] <= err_pipe[i-1];
      end
      for (int r = 0; r < 2; r++) begin
        a1[r] <= horner_step(ACC_W'(C[r][0]), len, C[r][1]);
        a2[r] <= horner_step(a1[r], len_s1, C[r][2]);
        a3[r] <= horner_step(a2[r], len_s2, C[r][3]);
        if (a3[r] > G_MAX) begin
          gain_s4[r] <= G_MAX[COEF_W-1:0];
        end else if (a3[r] < G_MIN) begin
          gain_s4[r] <= G_MIN[COEF_W-1:0];
        end else begin
          gain_s4[r] <= a3[r][COEF_W-1:0];
        end
        prod_s5[r] <= gain_s4[r] * err_pipe[3];
      end
      term_row1 <= prod_rnd[0][PROD_W-1:FRAC_G];
      term_row2 <= prod_rnd[1][PROD_W-1:FRAC_G];
    end
  end

  // Round-to-nearest bias ahead of the Q28.16 reduction.
  always_comb begin
    for (int r = 0; r < 2; r++) begin
      prod_rnd[r] = prod_s5[r] + HALF_G;
    end
  end

endmodule

@@ design/gslqr_merge.sv @@
// Merge stage: sums the lane terms per gain row, applies side, air and weak
// handling and saturates the torques. Uses gslqr_pkg.
module gslqr_merge #(
  parameter int DATA_WIDTH = gslqr_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [gslqr_pkg::TERM_W-1:0] row1 [gslqr_pkg::NUM_LANES],
  input  logic signed [gslqr_pkg::TERM_W-1:0] row2 [gslqr_pkg::NUM_LANES],
  input  gslqr_pkg::side_t                    side,
  output gslqr_pkg::res_t                     res
);
  import gslqr_pkg::*;

  localparam int NUM_PAIRS = NUM_LANES / 2;
  localparam int SAT_BITS  = (DATA_WIDTH > OUT_W) ? OUT_W :
                             ((DATA_WIDTH < 2) ? 2 : DATA_WIDTH);
  localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) << (SAT_BITS - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] x);
    if (x > SAT_HI) begin
      return SAT_HI[OUT_W-1:0];
    end else if (x < SAT_LO) begin
      return SAT_LO[OUT_W-1:0];
    end
    return x[OUT_W-1:0];
  endfunction

  logic signed [SUM_W-1:0] pair1 [NUM_PAIRS];
  logic signed [SUM_W-1:0] pair2 [NUM_PAIRS];
  logic signed [SUM_W-1:0] tot1, tot2;
  logic signed [SUM_W-1:0] wheel_s3, joint_s3;
  logic signed [SUM_W-1:0] t2 [NUM_LANES];
  side_t                   side_s1, side_s2, side_s3;

  // Airborne leg drops joint-row terms from position onward.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      t2[i] = (side.in_air && i >= 2) ? '0 : SUM_W'(row2[i]);
    end
  end

  // m1: pair sums, m2: row totals, m3: addends and leg side.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_PAIRS; k++) begin
        pair1[k] <= SUM_W'(row1[2*k]) + SUM_W'(row1[2*k+1]);
        pair2[k] <= t2[2*k] + t2[2*k+1];
      end
      side_s1 <= side;
      tot1    <= pair1[0] + pair1[1] + pair1[2];
      tot2    <= pair2[0] + pair2[1] + pair2[2];
      side_s2 <= side_s1;
      wheel_s3 <= tot1 + SUM_W'(side_s2.turn_torque);
      joint_s3 <= (side_s2.leg_side ? tot2 : -tot2) + SUM_W'(side_s2.coordinate_torque);
      side_s3  <= side_s2;
    end
  end

  // Forced zeros and saturation.
  always_comb begin
    res.wheel_torque   = (side_s3.weak_mode || side_s3.in_air) ? '0 : sat_out(wheel_s3);
    res.joint_torque   = side_s3.weak_mode ? '0 : sat_out(joint_s3);
    res.leg_force_zero = side_s3.weak_mode;
  end

endmodule

@@ design/gain_scheduled_lqr_torque_unit.sv @@
// Gain-scheduled LQR torque unit for one leg of a wheel-legged chassis.
// Input channel in_valid/in_ready carries one leg word: side, length, six
// Q16.16 state errors, air and weak flags, turn and coordination torques.
// Output channel out_valid/out_ready returns wheel and joint torque
// (Q16.16, saturated) and the leg-force-zero flag.
// Six lanes, one per state error, evaluate both gain polynomials from
// constant coefficients and form the gain*error products; a merge stage
// sums the rows and applies side, airborne and weak-mode handling.
// Throughput: one word per cycle while the skid register is empty. From input
// accept to out_valid a word passes 6 lane stages (3 Horner multiplies, clamp,
// product, rounding), 3 merge stages and the output register. Each lane
// multiplier is registered, so every stage takes a new word each cycle unless stalled.
// When the receiver stalls, the word in flight lands in a one-word skid
// register and the pipeline then holds with in_ready low until the skid
// drains. Synchronous reset clears all valid flags; no word is in flight.
// Depends on gslqr_pkg, gslqr_lane, gslqr_merge and the macros header.
`include "gain_scheduled_lqr_torque_unit_macros.svh"

module gain_scheduled_lqr_torque_unit #(
  parameter int DATA_WIDTH = gslqr_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               leg_side,
  input  logic [gslqr_pkg::LEN_W-1:0]        leg_length,
  input  logic signed [gslqr_pkg::ERR_W-1:0] theta_error,
  input  logic signed [gslqr_pkg::ERR_W-1:0] theta_rate_error,
  input  logic signed [gslqr_pkg::ERR_W-1:0] position_error,
  input  logic signed [gslqr_pkg::ERR_W-1:0] velocity_error,
  input  logic signed [gslqr_pkg::ERR_W-1:0] pitch_error,
  input  logic signed [gslqr_pkg::ERR_W-1:0] pitch_rate_error,
  input  logic                               in_air,
  input  logic signed [gslqr_pkg::ERR_W-1:0] turn_torque,
  input  logic signed [gslqr_pkg::ERR_W-1:0] coordinate_torque,
  input  logic                               weak_mode,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [gslqr_pkg::OUT_W-1:0] wheel_torque,
  output logic signed [gslqr_pkg::OUT_W-1:0] joint_torque,
  output logic                               leg_force_zero
);
  import gslqr_pkg::*;

  logic                    en;
  logic                    push;
  logic                    out_fire;
  logic                    skid_full;
  logic [PIPE_DEPTH-1:0]   vld;
  logic signed [ERR_W-1:0] errs [NUM_LANES];
  logic signed [TERM_W-1:0] row1 [NUM_LANES];
  logic signed [TERM_W-1:0] row2 [NUM_LANES];
  side_t                   side_in;
  side_t                   side_pipe [LANE_DEPTH];
  res_t                    res;
  res_t                    skid;

  // Pipeline advances whenever the skid register is free.
  assign en       = !skid_full;
  assign in_ready = en;
  assign push     = en && vld[PIPE_DEPTH-1];
  assign out_fire = out_valid && out_ready;

  assign errs[0] = theta_error;
  assign errs[1] = theta_rate_error;
  assign errs[2] = position_error;
  assign errs[3] = velocity_error;
  assign errs[4] = pitch_error;
  assign errs[5] = pitch_rate_error;

  assign side_in = '{leg_side: leg_side, in_air: in_air, weak_mode: weak_mode,
                     turn_torque: turn_torque, coordinate_torque: coordinate_torque};

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_valid};
    end
  end

  // Sideband delay matching the lane depth.
  always_ff @(posedge clk) begin
    if (en) begin
      side_pipe[0] <= side_in;
      for (int i = 1; i < LANE_DEPTH; i++) begin
        side_pipe[i] <= side_pipe[i-1];
      end
    end
  end

  // Lanes.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    gslqr_lane #(
      .LANE (g)
    ) u_lane (
      .clk       (clk),
      .en        (en),
      .len       (leg_length),
      .err       (errs[g]),
      .term_row1 (row1[g]),
      .term_row2 (row2[g])
    );
  end

  gslqr_merge #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_merge (
    .clk  (clk),
    .en   (en),
    .row1 (row1),
    .row2 (row2),
    .side (side_pipe[LANE_DEPTH-1]),
    .res  (res)
  );

  // Output register and skid control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_fire) begin
        skid_full <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  // Output and skid payload.
  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (out_fire) begin
        wheel_torque   <= skid.wheel_torque;
        joint_torque   <= skid.joint_torque;
        leg_force_zero <= skid.leg_force_zero;
      end
    end else if (push) begin
      if (!out_valid || out_fire) begin
        wheel_torque   <= res.wheel_torque;
        joint_torque   <= res.joint_torque;
        leg_force_zero <= res.leg_force_zero;
      end else begin
        skid <= res;
      end
    end
  end

  `GSLQR_ASSERT_NOW(a_skid_behind_out, skid_full, out_valid, "skid full with empty output")
  `GSLQR_ASSERT_NXT(a_stall_to_skid, push && out_valid && !out_ready, skid_full,
                    "stalled word not captured in skid")
  `GSLQR_ASSERT_NOW(a_weak_zero, out_valid && leg_force_zero,
                    wheel_torque == '0 && joint_torque == '0, "weak mode torque not zero")

endmodule
